>>> rtl/core/frg_pkg.sv
// ----------------------------------------------------------------------------
// frg_pkg: shared definitions for the fraction reduction block
// Default sizes, the sequencer state type and the status record of the
// iterative arithmetic units.
// ----------------------------------------------------------------------------
package frg_pkg;

	localparam int DATA_WIDTH_DEF = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GCD,
		ST_DIVN,
		ST_DIVD,
		ST_DONE
	} frg_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

>>> rtl/core/frg_gcd.sv
// ----------------------------------------------------------------------------
// frg_gcd: iterative binary GCD unit
// Finds the greatest common divisor of two nonzero magnitudes by halving and
// subtracting, one step per clock cycle.
// ----------------------------------------------------------------------------
module frg_gcd #(
	parameter int MAG_WIDTH = frg_pkg::DATA_WIDTH_DEF - 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [MAG_WIDTH-1:0] a_in,
	input  logic [MAG_WIDTH-1:0] b_in,
	output logic [MAG_WIDTH-1:0] gcd,
	output frg_pkg::unit_stat_t  stat
);
	import frg_pkg::*;

	localparam int KW = $clog2(MAG_WIDTH);

	logic [MAG_WIDTH-1:0] a_q;
	logic [MAG_WIDTH-1:0] b_q;
	logic [MAG_WIDTH-1:0] g_q;
	logic [KW-1:0]        k_q;
	logic                 busy_q;
	logic                 done_q;
	logic                 a_ge_b;
	logic [MAG_WIDTH-1:0] diff;

	assign a_ge_b = a_q >= b_q;
	assign diff   = a_ge_b ? (a_q - b_q) : (b_q - a_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && a_q == b_q) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a_in;
			b_q <= b_in;
			k_q <= '0;
		end else if (busy_q) begin
			if (a_q == b_q) begin
				g_q <= MAG_WIDTH'(a_q << k_q);
			end else if (!a_q[0] && !b_q[0]) begin
				a_q <= a_q >> 1;
				b_q <= b_q >> 1;
				k_q <= k_q + 1'b1;
			end else if (!a_q[0]) begin
				a_q <= a_q >> 1;
			end else if (!b_q[0]) begin
				b_q <= b_q >> 1;
			end else if (a_ge_b) begin
				a_q <= diff >> 1;
			end else begin
				b_q <= diff >> 1;
			end
		end
	end

	assign gcd       = g_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

>>> rtl/core/frg_divider.sv
// ----------------------------------------------------------------------------
// frg_divider: iterative restoring divider
// Produces one quotient bit per clock cycle by shift and trial subtraction.
// ----------------------------------------------------------------------------
module frg_divider #(
	parameter int MAG_WIDTH = frg_pkg::DATA_WIDTH_DEF - 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [MAG_WIDTH-1:0] dividend,
	input  logic [MAG_WIDTH-1:0] divisor,
	output logic [MAG_WIDTH-1:0] quotient,
	output frg_pkg::unit_stat_t  stat
);
	import frg_pkg::*;

	localparam int CW = $clog2(MAG_WIDTH);

	logic [MAG_WIDTH-1:0] rem_q;
	logic [MAG_WIDTH-1:0] quo_q;
	logic [MAG_WIDTH-1:0] div_q;
	logic [CW-1:0]        cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [MAG_WIDTH:0]   trial;
	logic [MAG_WIDTH:0]   diff;

	assign trial = {rem_q, quo_q[MAG_WIDTH-1]};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(MAG_WIDTH - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			if (!diff[MAG_WIDTH]) begin
				rem_q <= diff[MAG_WIDTH-1:0];
				quo_q <= {quo_q[MAG_WIDTH-2:0], 1'b1};
			end else begin
				rem_q <= trial[MAG_WIDTH-1:0];
				quo_q <= {quo_q[MAG_WIDTH-2:0], 1'b0};
			end
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

>>> rtl/core/fraction_reduce_gcd.sv
// ----------------------------------------------------------------------------
// fraction_reduce_gcd: reduce a signed fraction to lowest terms
// Sequencer around a binary GCD unit and one shared restoring divider.
// ----------------------------------------------------------------------------
// Each transaction carries a signed numerator and denominator and yields one
// result transaction with the fraction in lowest terms: the sign sits on the
// numerator and the denominator is positive. A zero denominator returns 0/0
// with the error flag set, a zero numerator returns 0/1, and the most negative
// input value is treated as one above it. The block works on one fraction at
// a time: s_tready is low from acceptance until the result is handed to the
// output register. A fraction passes through the GCD unit and then through two
// divisions in the shared divider, numerator first; the special cases skip both.
// The output register lets the next fraction be accepted while a result waits.
module fraction_reduce_gcd #(
	parameter int DATA_WIDTH = frg_pkg::DATA_WIDTH_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	// num_in, den_in
	input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]         s_tdata,
	output logic                                      m_tvalid,
	input  logic                                      m_tready,
	// num_out, den_out
	output logic [((2*DATA_WIDTH-1+7)/8)*8-1:0]       m_tdata,
	// zero_den_error
	output logic [0:0]                                m_tuser
);
	import frg_pkg::*;

	localparam int MW       = DATA_WIDTH - 1;
	localparam int OUT_TD_W = ((2*DATA_WIDTH-1+7)/8)*8;

	frg_state_t state_q;
	frg_state_t state_d;

	logic [DATA_WIDTH-1:0] num_raw;
	logic [DATA_WIDTH-1:0] den_raw;
	logic [DATA_WIDTH-1:0] num_twos;
	logic [DATA_WIDTH-1:0] den_twos;
	logic [MW-1:0]         num_mag;
	logic [MW-1:0]         den_mag;
	logic                  accept;

	logic [MW-1:0]         nmag_q;
	logic [MW-1:0]         dmag_q;
	logic                  neg_q;
	logic [MW-1:0]         qn_q;
	logic [DATA_WIDTH-1:0] res_num_q;
	logic [MW-1:0]         res_den_q;
	logic                  res_err_q;

	logic [DATA_WIDTH-1:0] out_num_q;
	logic [MW-1:0]         out_den_q;
	logic                  out_err_q;
	logic                  out_valid_q;
	logic                  out_free;

	logic                  gcd_start;
	logic [MW-1:0]         gcd_val;
	unit_stat_t            gcd_stat;
	logic                  div_start;
	logic                  div_sel_den;
	logic [MW-1:0]         div_dividend;
	logic [MW-1:0]         div_quo;
	unit_stat_t            div_stat;
	logic [DATA_WIDTH-1:0] qd_signed;

	assign num_raw  = s_tdata[DATA_WIDTH-1:0];
	assign den_raw  = s_tdata[2*DATA_WIDTH-1:DATA_WIDTH];
	assign num_twos = ~num_raw + 1'b1;
	assign den_twos = ~den_raw + 1'b1;

	always_comb begin
		if (!num_raw[DATA_WIDTH-1]) begin
			num_mag = num_raw[MW-1:0];
		end else if (num_raw[MW-1:0] == '0) begin
			num_mag = '1;
		end else begin
			num_mag = num_twos[MW-1:0];
		end
		if (!den_raw[DATA_WIDTH-1]) begin
			den_mag = den_raw[MW-1:0];
		end else if (den_raw[MW-1:0] == '0) begin
			den_mag = '1;
		end else begin
			den_mag = den_twos[MW-1:0];
		end
	end

	assign out_free = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (num_mag == '0 || den_mag == '0) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_GCD;
					end
				end
			end
			ST_GCD: begin
				if (gcd_stat.done) begin
					state_d = ST_DIVN;
				end
			end
			ST_DIVN: begin
				if (div_stat.done) begin
					state_d = ST_DIVD;
				end
			end
			ST_DIVD: begin
				if (div_stat.done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready    = 1'b0;
		gcd_start   = 1'b0;
		div_start   = 1'b0;
		div_sel_den = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready  = 1'b1;
				gcd_start = s_tvalid && num_mag != '0 && den_mag != '0;
			end
			ST_GCD: begin
				div_start = gcd_stat.done;
			end
			ST_DIVN: begin
				div_start   = div_stat.done;
				div_sel_den = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign div_dividend = div_sel_den ? dmag_q : nmag_q;
	assign qd_signed    = neg_q ? (~{1'b0, qn_q} + 1'b1) : {1'b0, qn_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			nmag_q <= num_mag;
			dmag_q <= den_mag;
			neg_q  <= num_raw[DATA_WIDTH-1] ^ den_raw[DATA_WIDTH-1];
			if (den_mag == '0) begin
				res_num_q <= '0;
				res_den_q <= '0;
				res_err_q <= 1'b1;
			end else if (num_mag == '0) begin
				res_num_q <= '0;
				res_den_q <= MW'(1);
				res_err_q <= 1'b0;
			end
		end
		if (state_q == ST_DIVN && div_stat.done) begin
			qn_q <= div_quo;
		end
		if (state_q == ST_DIVD && div_stat.done) begin
			res_num_q <= qd_signed;
			res_den_q <= div_quo;
			res_err_q <= 1'b0;
		end
		if (state_q == ST_DONE && out_free) begin
			out_num_q <= res_num_q;
			out_den_q <= res_den_q;
			out_err_q <= res_err_q;
		end
	end

	frg_gcd #(
		.MAG_WIDTH(MW)
	) u_gcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (gcd_start),
		.a_in   (num_mag),
		.b_in   (den_mag),
		.gcd    (gcd_val),
		.stat   (gcd_stat)
	);

	frg_divider #(
		.MAG_WIDTH(MW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (gcd_val),
		.quotient (div_quo),
		.stat     (div_stat)
	);

	assign m_tvalid   = out_valid_q;
	assign m_tdata    = OUT_TD_W'({out_den_q, out_num_q});
	assign m_tuser[0] = out_err_q;

endmodule

>>> rtl/core/frg_checker.sv
// ----------------------------------------------------------------------------
// frg_checker: port-level checks for the fraction reduction block
// Watches the stream ports and is bound to the top level.
// ----------------------------------------------------------------------------
module frg_checker #(
	parameter int DATA_WIDTH = frg_pkg::DATA_WIDTH_DEF
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_tvalid,
	input logic                                s_tready,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [((2*DATA_WIDTH-1+7)/8)*8-1:0] m_tdata,
	input logic [0:0]                          m_tuser
);
	import frg_pkg::*;

	logic [DATA_WIDTH-1:0] chk_num;
	logic [DATA_WIDTH-2:0] chk_den;

	assign chk_num = m_tdata[DATA_WIDTH-1:0];
	assign chk_den = m_tdata[2*DATA_WIDTH-2:DATA_WIDTH];

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("Output transaction changed while stalled.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("Input accepted while a fraction is in progress.");

	a_error_zeros: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> chk_num == '0 && chk_den == '0)
		else $error("Error result carries nonzero data.");

	a_den_positive: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> chk_den != '0)
		else $error("Valid result has a zero denominator.");

	a_zero_num: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] && chk_num == '0 |-> chk_den == 1)
		else $error("Zero numerator not reduced to 0/1.");

endmodule

bind fraction_reduce_gcd frg_checker #(
	.DATA_WIDTH(DATA_WIDTH)
) u_frg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for fraction_reduce_gcd
// Drives signed fractions into the stream input and checks each reduced
// fraction against a table entry or a behavioral predictor. A short table covers
// zero and extreme operands, then random fractions, most with built-in common
// factors, run under three mixes of sender and receiver stalls, the last with none.
// ----------------------------------------------------------------------------
module tb;

	import frg_pkg::*;

	localparam int W = DATA_WIDTH_DEF;
	localparam int S_BITS = ((2*W+7)/8)*8;
	localparam int M_BITS = ((2*W-1+7)/8)*8;
	localparam int RANDOM_PER_PHASE = 360;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 150;
	localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINUS_ONE = {W{1'b1}};

	typedef struct packed {
		logic [W-1:0] num;
		logic [W-2:0] den;
		logic         err;
	} frac_t;

	typedef struct packed {
		logic [W-1:0] num;
		logic [W-1:0] den;
		logic         typed;
		frac_t        want;
	} row_t;

	localparam int N_ROWS = 24;
	localparam row_t DIRECTED [0:N_ROWS-1] = '{
		'{32'd0,        32'd5,        1'b1, '{32'd0,      31'd1,          1'b0}},
		'{32'd7,        32'd0,        1'b1, '{32'd0,      31'd0,          1'b1}},
		'{32'd0,        32'd0,        1'b1, '{32'd0,      31'd0,          1'b1}},
		'{MOST_NEG,     32'd0,        1'b1, '{32'd0,      31'd0,          1'b1}},
		'{32'd0,        MOST_NEG,     1'b1, '{32'd0,      31'd1,          1'b0}},
		'{MOST_NEG,     32'd1,        1'b1, '{32'h80000001, 31'd1,        1'b0}},
		'{32'd1,        MOST_NEG,     1'b1, '{MINUS_ONE,  31'h7fffffff,   1'b0}},
		'{MOST_NEG,     MOST_NEG,     1'b1, '{32'd1,      31'd1,          1'b0}},
		'{MOST_POS,     MOST_POS,     1'b1, '{32'd1,      31'd1,          1'b0}},
		'{MOST_POS,     MINUS_ONE,    1'b1, '{32'h80000001, 31'd1,        1'b0}},
		'{MINUS_ONE,    MINUS_ONE,    1'b1, '{32'd1,      31'd1,          1'b0}},
		'{32'd1,        MOST_POS,     1'b1, '{32'd1,      31'h7fffffff,   1'b0}},
		'{MOST_POS,     32'd1,        1'b1, '{MOST_POS,   31'd1,          1'b0}},
		'{32'd0,        32'hfffffffd, 1'b1, '{32'd0,      31'd1,          1'b0}},
		'{32'hfffffff9, 32'd0,        1'b1, '{32'd0,      31'd0,          1'b1}},
		'{32'd6,        32'd4,        1'b0, '0},
		'{32'hfffffffa, 32'd4,        1'b0, '0},
		'{32'd6,        32'hfffffffc, 1'b0, '0},
		'{32'hfffffffa, 32'hfffffffc, 1'b0, '0},
		'{32'h40000000, 32'h00010000, 1'b0, '0},
		'{MOST_POS,     32'h7ffffffe, 1'b0, '0},
		'{32'h6d73e55f, 32'h43a53f82, 1'b0, '0},
		'{32'h55555555, 32'haaaaaaaa, 1'b0, '0},
		'{32'haaaaaaaa, 32'h55555555, 1'b0, '0}
	};

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [S_BITS-1:0] s_tdata;
	logic              m_tvalid;
	logic              m_tready;
	logic [M_BITS-1:0] m_tdata;
	logic [0:0]        m_tuser;

	frac_t pending_fractions[$];
	frac_t got_fraction;
	frac_t want_fraction;
	int    mismatches;
	int    quiet_cycles;
	int    send_idle_pct;
	int    recv_idle_pct;

	fraction_reduce_gcd #(
		.DATA_WIDTH(W)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic frac_t reduce_fraction(input logic [W-1:0] num, input logic [W-1:0] den);
		logic [W-1:0] nmag;
		logic [W-1:0] dmag;
		logic [W-1:0] a;
		logic [W-1:0] b;
		logic [W-1:0] r;
		logic [W-1:0] q;
		frac_t        res;
		nmag = num[W-1] ? (~num + 1'b1) : num;
		dmag = den[W-1] ? (~den + 1'b1) : den;
		if (num == MOST_NEG) begin
			nmag = MOST_POS;
		end
		if (den == MOST_NEG) begin
			dmag = MOST_POS;
		end
		res = '0;
		if (dmag == '0) begin
			res.err = 1'b1;
			return res;
		end
		if (nmag == '0) begin
			res.den = (W-1)'(1);
			return res;
		end
		a = nmag;
		b = dmag;
		while (b != '0) begin
			r = a % b;
			a = b;
			b = r;
		end
		q = nmag / a;
		res.num = (num[W-1] != den[W-1]) ? (~q + 1'b1) : q;
		res.den = (W-1)'(dmag / a);
		return res;
	endfunction

	function automatic logic [W-1:0] corner_value();
		case ($urandom_range(5))
			0: return '0;
			1: return MOST_NEG;
			2: return MOST_POS;
			3: return MINUS_ONE;
			4: return W'(1);
			default: return W'($urandom_range(1, 16));
		endcase
	endfunction

	task automatic pick_fraction(output logic [W-1:0] num, output logic [W-1:0] den);
		int           kind;
		int           gw;
		int           aw;
		int           bw;
		logic [W-1:0] g;
		logic [W-1:0] a;
		logic [W-1:0] b;
		kind = $urandom_range(99);
		if (kind < 12) begin
			num = $urandom;
			den = $urandom;
		end else if (kind < 22) begin
			num = corner_value();
			den = corner_value();
		end else begin
			if (kind < 32) begin
				g = W'(1) << $urandom_range(W-2);
				a = W'($urandom_range(1, 7)) << $urandom_range(W-4);
				b = W'($urandom_range(1, 7)) << $urandom_range(W-4);
			end else begin
				gw = $urandom_range(0, W-2);
				aw = $urandom_range(0, W-1-gw);
				bw = $urandom_range(0, W-1-gw);
				g = (({W{1'b1}} >> (W-gw)) & W'($urandom)) | W'(1);
				a = ({W{1'b1}} >> (W-aw)) & W'($urandom);
				b = ({W{1'b1}} >> (W-bw)) & W'($urandom);
			end
			num = g * a;
			den = g * b;
			if ($urandom_range(1)) begin
				num = ~num + 1'b1;
			end
			if ($urandom_range(1)) begin
				den = ~den + 1'b1;
			end
		end
	endtask

	task automatic send_fraction(input logic [W-1:0] num, input logic [W-1:0] den,
			input logic typed, input frac_t want);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat (($urandom_range(3) == 0) ? $urandom_range(1, 200) : $urandom_range(1, 4))
				@(posedge clk);
		end
		s_tdata <= S_BITS'({den, num});
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		pending_fractions.push_back(typed ? want : reduce_fraction(num, den));
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_fractions.size() != 0);
	endtask

	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(99) < recv_idle_pct) begin
				m_tready <= 1'b0;
				repeat (($urandom_range(7) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 3))
					@(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_fraction.num = m_tdata[W-1:0];
			got_fraction.den = m_tdata[2*W-2:W];
			got_fraction.err = m_tuser[0];
			if (pending_fractions.size() == 0) begin
				$error("result transaction with nothing expected: num_out %0d den_out %0d",
					$signed(got_fraction.num), got_fraction.den);
				mismatches++;
			end else begin
				want_fraction = pending_fractions.pop_front();
				if (got_fraction.num !== want_fraction.num) begin
					$error("num_out: expected %0d, actual %0d",
						$signed(want_fraction.num), $signed(got_fraction.num));
					mismatches++;
				end
				if (got_fraction.den !== want_fraction.den) begin
					$error("den_out: expected %0d, actual %0d",
						want_fraction.den, got_fraction.den);
					mismatches++;
				end
				if (got_fraction.err !== want_fraction.err) begin
					$error("zero_den_error: expected %0b, actual %0b",
						want_fraction.err, got_fraction.err);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		logic [W-1:0] num;
		logic [W-1:0] den;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		mismatches = 0;
		quiet_cycles = 0;
		send_idle_pct = 29;
		recv_idle_pct = 46;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_ROWS; i++) begin
			send_fraction(DIRECTED[i].num, DIRECTED[i].den, DIRECTED[i].typed, DIRECTED[i].want);
		end

		for (int phase = 0; phase < 3; phase++) begin
			wait_drained();
			send_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 46 : 0;
			recv_idle_pct = (phase == 0) ? 46 : (phase == 1) ? 29 : 0;
			for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
				pick_fraction(num, den);
				send_fraction(num, den, 1'b0, '0);
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/core/frg_pkg.sv
rtl/core/frg_gcd.sv
rtl/core/frg_divider.sv
rtl/core/fraction_reduce_gcd.sv
rtl/core/frg_checker.sv
tb/tb.sv
